@@ hdl/csq_pkg.sv @@
// ----------------------------------------------------------------------------
// csq_pkg
// Shared types and constants for the counting semaphore with FIFO wait queue.
// ----------------------------------------------------------------------------
package csq_pkg;

  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int THREAD_ID_BITS_DEF = 8;

  localparam int OP_W     = 2;
  localparam int ID_W     = 8;
  localparam int INIT_W   = 15;
  localparam int STATUS_W = 2;
  localparam int ACTION_W = 2;
  localparam int COUNT_W  = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'd32767;

  typedef enum logic [OP_W-1:0] {
    OP_OPEN   = 2'd0,
    OP_WAIT   = 2'd1,
    OP_SIGNAL = 2'd2,
    OP_CLOSE  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_CLOSED    = 2'd1,
    ST_FULL      = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE     = 2'd0,
    ACT_BLOCKED  = 2'd1,
    ACT_RELEASED = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DRAIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    capture;     // latch the incoming word
    logic    load;        // count <= initial_count
    logic    dec;
    logic    inc;
    logic    push;
    logic    pop;
    logic    rewind;      // head, tail and total back to zero
    logic    set_closed;
    logic    clr_closed;
    logic    emit;        // issue a result word
    status_t status;
    action_t action;
    logic    use_id;      // released_id from the queue head
    logic    last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic closed;
    logic cnt_nonpos;
    logic cnt_neg;
    logic cnt_max;
    logic full;
    logic empty;
    logic one_left;
  } dp_flags_t;

endpackage

@@ hdl/csq_dp.sv @@
// ----------------------------------------------------------------------------
// csq_dp
// Datapath: semaphore count, closed flag, waiter queue and result register.
// ----------------------------------------------------------------------------
module csq_dp #(
  parameter int QUEUE_DEPTH    = csq_pkg::QUEUE_DEPTH_DEF,
  parameter int THREAD_ID_BITS = csq_pkg::THREAD_ID_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  csq_pkg::dp_cmd_t                cmd,
  output csq_pkg::dp_flags_t              flags,
  input  logic [csq_pkg::ID_W-1:0]        thread_id,
  input  logic [csq_pkg::INIT_W-1:0]      initial_count,
  output logic                            done,
  output logic [csq_pkg::STATUS_W-1:0]    status,
  output logic [csq_pkg::ACTION_W-1:0]    action,
  output logic [csq_pkg::ID_W-1:0]        released_id,
  output logic                            last
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [csq_pkg::COUNT_W-1:0] count;
  logic                        closed;
  logic [PTR_W-1:0]            head;
  logic [PTR_W-1:0]            tail;
  logic [CNT_W-1:0]            total;
  logic [PTR_W-1:0]            head_next;
  logic [THREAD_ID_BITS-1:0]   mem [QUEUE_DEPTH];
  logic [THREAD_ID_BITS-1:0]   rd_data;
  logic [THREAD_ID_BITS-1:0]   tid_q;
  logic [csq_pkg::INIT_W-1:0]  init_q;
  logic [15:0]                 tid_wide;
  logic [15:0]                 rd_wide;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign tid_wide = 16'(thread_id);
  assign rd_wide  = 16'(rd_data);

  // read address follows the head as it will be, so rd_data tracks the oldest waiter
  always_comb begin
    if (cmd.rewind) begin
      head_next = '0;
    end else if (cmd.pop) begin
      head_next = next_slot(head);
    end else begin
      head_next = head;
    end
  end

  always_comb begin
    flags.closed     = closed;
    flags.cnt_neg    = count[csq_pkg::COUNT_W-1];
    flags.cnt_nonpos = count[csq_pkg::COUNT_W-1] | (count == '0);
    flags.cnt_max    = (count == csq_pkg::COUNT_MAX);
    flags.full       = (total == CNT_W'(QUEUE_DEPTH));
    flags.empty      = (total == '0);
    flags.one_left   = (total == CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= tid_q;
    end
    rd_data <= mem[head_next];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tid_q  <= tid_wide[THREAD_ID_BITS-1:0];
      init_q <= initial_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      closed <= 1'b0;
      head   <= '0;
      tail   <= '0;
      total  <= '0;
    end else begin
      if (cmd.load) begin
        count <= {1'b0, init_q};
      end else if (cmd.dec) begin
        count <= count - 16'd1;
      end else if (cmd.inc) begin
        count <= count + 16'd1;
      end

      if (cmd.set_closed) begin
        closed <= 1'b1;
      end else if (cmd.clr_closed) begin
        closed <= 1'b0;
      end

      head <= head_next;

      if (cmd.rewind) begin
        tail <= '0;
      end else if (cmd.push) begin
        tail <= next_slot(tail);
      end

      if (cmd.rewind) begin
        total <= '0;
      end else if (cmd.push) begin
        total <= total + CNT_W'(1);
      end else if (cmd.pop) begin
        total <= total - CNT_W'(1);
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    status      <= cmd.status;
    action      <= cmd.action;
    released_id <= cmd.use_id ? rd_wide[csq_pkg::ID_W-1:0] : '0;
    last        <= cmd.last;
  end

endmodule

@@ hdl/csq_ctrl.sv @@
// ----------------------------------------------------------------------------
// csq_ctrl
// Controller: accepts a request word, decodes it against datapath flags and
// sequences the drain of the wait queue on close.
// ----------------------------------------------------------------------------
module csq_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [csq_pkg::OP_W-1:0]   opcode,
  output logic                       busy,
  output csq_pkg::dp_cmd_t           cmd,
  input  csq_pkg::dp_flags_t         flags
);

  csq_pkg::state_t  state;
  csq_pkg::state_t  state_next;
  csq_pkg::opcode_t op;
  csq_pkg::opcode_t op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csq_pkg::S_IDLE;
      op    <= csq_pkg::OP_OPEN;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    busy           = (state != csq_pkg::S_IDLE);
    cmd            = '0;
    cmd.status     = csq_pkg::ST_OK;
    cmd.action     = csq_pkg::ACT_NONE;
    cmd.last       = 1'b1;

    case (state)
      csq_pkg::S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          op_next     = csq_pkg::opcode_t'(opcode);
          state_next  = csq_pkg::S_EXEC;
        end
      end

      csq_pkg::S_EXEC: begin
        state_next = csq_pkg::S_IDLE;
        cmd.emit   = 1'b1;
        if (op == csq_pkg::OP_OPEN) begin
          if (!flags.empty) begin
            cmd.status = csq_pkg::ST_FULL;
          end else begin
            cmd.load       = 1'b1;
            cmd.rewind     = 1'b1;
            cmd.clr_closed = 1'b1;
          end
        end else if (flags.closed) begin
          cmd.status = csq_pkg::ST_CLOSED;
        end else begin
          case (op)
            csq_pkg::OP_WAIT: begin
              if (flags.cnt_nonpos) begin
                if (flags.full) begin
                  cmd.status = csq_pkg::ST_FULL;
                end else begin
                  cmd.dec    = 1'b1;
                  cmd.push   = 1'b1;
                  cmd.action = csq_pkg::ACT_BLOCKED;
                end
              end else begin
                cmd.dec = 1'b1;
              end
            end
            csq_pkg::OP_SIGNAL: begin
              if (flags.cnt_max) begin
                cmd.status = csq_pkg::ST_SATURATED;
              end else begin
                cmd.inc = 1'b1;
                // count still not positive after the increment
                if (flags.cnt_neg && !flags.empty) begin
                  cmd.pop    = 1'b1;
                  cmd.action = csq_pkg::ACT_RELEASED;
                  cmd.use_id = 1'b1;
                end
              end
            end
            csq_pkg::OP_CLOSE: begin
              cmd.set_closed = 1'b1;
              if (!flags.empty) begin
                cmd.emit   = 1'b0;
                state_next = csq_pkg::S_DRAIN;
              end
            end
            default: begin
              cmd.emit = 1'b1;
            end
          endcase
        end
      end

      csq_pkg::S_DRAIN: begin
        cmd.emit   = 1'b1;
        cmd.pop    = 1'b1;
        cmd.action = csq_pkg::ACT_RELEASED;
        cmd.use_id = 1'b1;
        cmd.last   = flags.one_left;
        if (flags.one_left) begin
          cmd.rewind = 1'b1;
          state_next = csq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = csq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/counting_semaphore_wait_queue_unit.sv @@
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_unit
// Counting semaphore with a FIFO queue of blocked thread ids.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low. Open, wait,
// signal and close on an empty queue give one result word, held on the
// result ports for a single cycle with done high, registered from the
// execute state; the receiver cannot stall, so it must capture every word
// marked by done. Close with N waiters gives N words on consecutive cycles,
// oldest waiter first, the final one with last set; busy stays high until
// the last of them has been issued. The controller decodes each request in
// its execute state, and during a drain the queue memory delivers one entry
// per cycle.
module counting_semaphore_wait_queue_unit #(
  parameter int QUEUE_DEPTH    = csq_pkg::QUEUE_DEPTH_DEF,
  parameter int THREAD_ID_BITS = csq_pkg::THREAD_ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [csq_pkg::OP_W-1:0]     opcode,
  input  logic [csq_pkg::ID_W-1:0]     thread_id,
  input  logic [csq_pkg::INIT_W-1:0]   initial_count,
  output logic                         done,
  output logic [csq_pkg::STATUS_W-1:0] status,
  output logic [csq_pkg::ACTION_W-1:0] action,
  output logic [csq_pkg::ID_W-1:0]     released_id,
  output logic                         last
);

  csq_pkg::dp_cmd_t   cmd;
  csq_pkg::dp_flags_t flags;

  csq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .busy   (busy),
    .cmd    (cmd),
    .flags  (flags)
  );

  csq_dp #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .flags         (flags),
    .thread_id     (thread_id),
    .initial_count (initial_count),
    .done          (done),
    .status        (status),
    .action        (action),
    .released_id   (released_id),
    .last          (last)
  );

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for counting_semaphore_wait_queue_unit. Requests go in
// through the start/busy handshake. A behavioural semaphore with its own
// count, closed flag and waiter list predicts every result word, and each
// word marked by done is compared field by field with the oldest prediction.
// Directed checks cover limits, refusals, the closed state and a full queue.
// Random episodes of open/wait/signal/close traffic then run with the sender
// idling at several rates.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH         = csq_pkg::QUEUE_DEPTH_DEF;
  localparam int LEVEL_MAX      = 32767;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_RUN  = 38;

  typedef struct packed {
    csq_pkg::status_t          status;
    csq_pkg::action_t          action;
    logic [csq_pkg::ID_W-1:0]  id;
    logic                      last;
  } sem_word_t;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic [csq_pkg::OP_W-1:0]     opcode;
  logic [csq_pkg::ID_W-1:0]     thread_id;
  logic [csq_pkg::INIT_W-1:0]   initial_count;
  logic                         done;
  logic [csq_pkg::STATUS_W-1:0] status;
  logic [csq_pkg::ACTION_W-1:0] action;
  logic [csq_pkg::ID_W-1:0]     released_id;
  logic                         last;

  // behavioural semaphore
  logic signed [csq_pkg::COUNT_W-1:0] sem_level;
  logic                               sem_shut;
  logic [csq_pkg::ID_W-1:0]           wait_line[$];
  sem_word_t                          expected_words[$];

  int sender_idle_pct;
  int requests_taken;
  int words_checked;
  int errors;
  int n_blocked;
  int n_released;
  int n_refused;
  int n_saturated;
  int n_closed;
  int quiet_cycles;

  counting_semaphore_wait_queue_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .thread_id     (thread_id),
    .initial_count (initial_count),
    .done          (done),
    .status        (status),
    .action        (action),
    .released_id   (released_id),
    .last          (last)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void push_word(csq_pkg::status_t st, csq_pkg::action_t act,
                                    logic [csq_pkg::ID_W-1:0] id, logic lst);
    sem_word_t w;
    w.status = st;
    w.action = act;
    w.id     = id;
    w.last   = lst;
    expected_words.push_back(w);
  endfunction

  task automatic predict_request(csq_pkg::opcode_t op, logic [csq_pkg::ID_W-1:0] id,
                                 logic [csq_pkg::INIT_W-1:0] load);
    logic [csq_pkg::ID_W-1:0] out_id;
    if (op == csq_pkg::OP_OPEN) begin
      if (wait_line.size() != 0) begin
        push_word(csq_pkg::ST_FULL, csq_pkg::ACT_NONE, '0, 1'b1);
      end else begin
        sem_level = signed'({1'b0, load});
        sem_shut  = 1'b0;
        push_word(csq_pkg::ST_OK, csq_pkg::ACT_NONE, '0, 1'b1);
      end
    end else if (sem_shut) begin
      push_word(csq_pkg::ST_CLOSED, csq_pkg::ACT_NONE, '0, 1'b1);
    end else if (op == csq_pkg::OP_WAIT) begin
      if (sem_level <= 0) begin
        if (wait_line.size() >= QDEPTH) begin
          push_word(csq_pkg::ST_FULL, csq_pkg::ACT_NONE, '0, 1'b1);
        end else begin
          sem_level = sem_level - 1;
          wait_line.push_back(id);
          push_word(csq_pkg::ST_OK, csq_pkg::ACT_BLOCKED, '0, 1'b1);
        end
      end else begin
        sem_level = sem_level - 1;
        push_word(csq_pkg::ST_OK, csq_pkg::ACT_NONE, '0, 1'b1);
      end
    end else if (op == csq_pkg::OP_SIGNAL) begin
      if (sem_level >= LEVEL_MAX) begin
        push_word(csq_pkg::ST_SATURATED, csq_pkg::ACT_NONE, '0, 1'b1);
      end else begin
        sem_level = sem_level + 1;
        if (sem_level <= 0 && wait_line.size() != 0) begin
          out_id = wait_line.pop_front();
          push_word(csq_pkg::ST_OK, csq_pkg::ACT_RELEASED, out_id, 1'b1);
        end else begin
          push_word(csq_pkg::ST_OK, csq_pkg::ACT_NONE, '0, 1'b1);
        end
      end
    end else begin
      sem_shut = 1'b1;
      if (wait_line.size() == 0) begin
        push_word(csq_pkg::ST_OK, csq_pkg::ACT_NONE, '0, 1'b1);
      end
      // drain oldest first, last flag on the final word only
      while (wait_line.size() != 0) begin
        out_id = wait_line.pop_front();
        push_word(csq_pkg::ST_OK, csq_pkg::ACT_RELEASED, out_id, wait_line.size() == 0);
      end
    end
  endtask

  task automatic compare_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0d ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  task automatic check_word();
    sem_word_t want;
    if (expected_words.size() == 0) begin
      errors++;
      $display("%0d ns: unexpected word, status %0h action %0h id %0h last %0b",
               $time, status, action, released_id, last);
    end else begin
      want = expected_words.pop_front();
      compare_field("status", 8'(want.status), 8'(status));
      compare_field("action", 8'(want.action), 8'(action));
      compare_field("released_id", want.id, released_id);
      compare_field("last", 8'(want.last), 8'(last));
      words_checked++;
      case (want.status)
        csq_pkg::ST_FULL:      n_refused++;
        csq_pkg::ST_SATURATED: n_saturated++;
        csq_pkg::ST_CLOSED:    n_closed++;
        default:               ;
      endcase
      if (want.action == csq_pkg::ACT_BLOCKED) n_blocked++;
      if (want.action == csq_pkg::ACT_RELEASED) n_released++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sem_level = '0;
      sem_shut  = 1'b0;
      wait_line.delete();
      expected_words.delete();
    end else begin
      if (start && !busy) begin
        predict_request(csq_pkg::opcode_t'(opcode), thread_id, initial_count);
        requests_taken++;
      end
      if (done) check_word();
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0d ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a rising edge; returns at the edge that takes the word
  task automatic send_word(csq_pkg::opcode_t op, logic [csq_pkg::ID_W-1:0] id,
                           logic [csq_pkg::INIT_W-1:0] load);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    opcode        <= op;
    thread_id     <= id;
    initial_count <= load;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    do @(negedge clk); while (expected_words.size() != 0);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [csq_pkg::INIT_W-1:0] pick_load();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return csq_pkg::INIT_W'($urandom_range(3));
    if (roll < 80) return csq_pkg::INIT_W'(LEVEL_MAX - $urandom_range(1));
    return csq_pkg::INIT_W'($urandom_range(LEVEL_MAX));
  endfunction

  task automatic test_limits();
    send_word(csq_pkg::OP_OPEN, 8'hFF, 15'h7FFE);
    send_word(csq_pkg::OP_SIGNAL, 8'h00, 15'h0000);
    send_word(csq_pkg::OP_SIGNAL, 8'hFF, 15'h7FFF);   // at the ceiling
    send_word(csq_pkg::OP_WAIT, 8'h00, 15'h7FFF);
    send_word(csq_pkg::OP_OPEN, 8'h00, 15'h0000);
    send_word(csq_pkg::OP_WAIT, 8'hFF, 15'h0000);     // blocks
    send_word(csq_pkg::OP_OPEN, 8'h00, 15'h1234);     // refused, waiter queued
    send_word(csq_pkg::OP_SIGNAL, 8'h00, 15'h0000);   // hands off to the waiter
    send_word(csq_pkg::OP_CLOSE, 8'h5A, 15'h0000);    // nobody queued
    send_word(csq_pkg::OP_WAIT, 8'hA5, 15'h0000);
    send_word(csq_pkg::OP_SIGNAL, 8'h00, 15'h7FFF);
    send_word(csq_pkg::OP_CLOSE, 8'h00, 15'h0000);
  endtask

  task automatic test_full_queue();
    int k;
    send_word(csq_pkg::OP_OPEN, 8'h00, 15'h0000);
    for (k = 0; k < QDEPTH; k++) begin
      send_word(csq_pkg::OP_WAIT, (k % 2) ? ~csq_pkg::ID_W'(k) : csq_pkg::ID_W'(k),
                15'h0000);
    end
    send_word(csq_pkg::OP_WAIT, 8'hEE, 15'h0000);     // no room left
    send_word(csq_pkg::OP_CLOSE, 8'h00, 15'h0000);    // drains all sixteen
  endtask

  task automatic test_random_traffic(int idle_pct, int count);
    int sent;
    int wait_bias;
    int run_len;
    int k;
    int roll;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < count) begin
      send_word(csq_pkg::OP_OPEN, csq_pkg::ID_W'($urandom_range(255)), pick_load());
      sent++;
      wait_bias = $urandom_range(25, 85);
      run_len   = $urandom_range(4, 24);
      for (k = 0; k < run_len; k++) begin
        roll = $urandom_range(99);
        if (roll < 4) begin
          send_word(csq_pkg::OP_CLOSE, csq_pkg::ID_W'($urandom_range(255)),
                    csq_pkg::INIT_W'($urandom_range(LEVEL_MAX)));
        end else if (roll < 8) begin
          send_word(csq_pkg::OP_OPEN, csq_pkg::ID_W'($urandom_range(255)), pick_load());
        end else if ($urandom_range(99) < wait_bias) begin
          send_word(csq_pkg::OP_WAIT, csq_pkg::ID_W'($urandom_range(255)),
                    csq_pkg::INIT_W'($urandom_range(LEVEL_MAX)));
        end else begin
          send_word(csq_pkg::OP_SIGNAL, csq_pkg::ID_W'($urandom_range(255)),
                    csq_pkg::INIT_W'($urandom_range(LEVEL_MAX)));
        end
        sent++;
      end
      if ($urandom_range(1)) begin
        send_word(csq_pkg::OP_CLOSE, csq_pkg::ID_W'($urandom_range(255)),
                  csq_pkg::INIT_W'($urandom_range(LEVEL_MAX)));
        sent++;
      end
    end
    wait_quiet();
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    opcode          = csq_pkg::OP_OPEN;
    thread_id       = '0;
    initial_count   = '0;
    sender_idle_pct = 0;
    requests_taken  = 0;
    words_checked   = 0;
    errors          = 0;
    n_blocked       = 0;
    n_released      = 0;
    n_refused       = 0;
    n_saturated     = 0;
    n_closed        = 0;
    quiet_cycles    = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_limits();
    test_full_queue();
    wait_quiet();
    test_random_traffic(0, ITEMS_PER_RUN);
    test_random_traffic(74, ITEMS_PER_RUN);
    test_random_traffic(34, ITEMS_PER_RUN);

    if (expected_words.size() != 0) begin
      errors++;
      $display("%0d ns: %0d expected words never arrived", $time, expected_words.size());
    end
    $display("Covered %0d requests and %0d result words: %0d blocked, %0d released,",
             requests_taken, words_checked, n_blocked, n_released);
    $display("%0d refused, %0d saturated, %0d on a closed semaphore; %0d errors",
             n_refused, n_saturated, n_closed, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
